// ----- sv/callsign_hash22_macros.svh -----
// ----------------------------------------------------------------------------
// callsign_hash22 assertion macros
// Shared assertion shorthands for the callsign hash checker.
// ----------------------------------------------------------------------------
`ifndef CALLSIGN_HASH22_MACROS_SVH
`define CALLSIGN_HASH22_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define CH22_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define CH22_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- sv/ch22_pkg.sv -----
// ----------------------------------------------------------------------------
// ch22_pkg
// Types, constants and character helpers for the 22-bit callsign hash.
// ----------------------------------------------------------------------------
package ch22_pkg;

  // Longest trimmed callsign accepted
  localparam logic [4:0] MAX_SYMBOLS = 5'd11;
  // Positions the value is padded to before hashing
  localparam logic [3:0] PAD_POSITIONS = 4'd11;
  // Hash multiplier (36 bits)
  localparam logic [35:0] HASH_MULT = 36'd47055833459;

  localparam logic [7:0] CODE_SPACE = 8'h20;

  // Input beat: one character
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } hash_in_t;

  // Output beat: one key
  typedef struct packed {
    logic [21:0] key22;
    logic [11:0] key12;
    logic        hash_error;
  } hash_out_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] idx;
  } sym_t;

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_white(input logic [7:0] c);
    return (c == CODE_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Index in " 0-9A-Z/" after folding lower case
  function automatic sym_t sym_lookup(input logic [7:0] code);
    logic [7:0] c;
    sym_t       s;
    c = code;
    s = '{valid: 1'b0, idx: 6'd0};
    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
    if (c == CODE_SPACE) begin
      s = '{valid: 1'b1, idx: 6'd0};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = '{valid: 1'b1, idx: 6'(c - 8'h30 + 8'd1)};
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      s = '{valid: 1'b1, idx: 6'(c - 8'h41 + 8'd11)};
    end else if (c == 8'h2F) begin
      s = '{valid: 1'b1, idx: 6'd37};
    end
    return s;
  endfunction

endpackage

// ----- sv/callsign_hash22.sv -----
// ----------------------------------------------------------------------------
// callsign_hash22
// Trims and folds a callsign fed one character a beat, packs it base 38 and
// returns its 22-bit and 12-bit hash keys.
// ----------------------------------------------------------------------------
//  channel | direction | payload     | beats
//  char    | in        | hash_in_t   | one character, last_char ends callsign
//  key     | out       | hash_out_t  | one key per callsign
//
// Characters other than whitespace shift in their interior spaces, then
// themselves, through the shared x38 multiply-add unit. A last character
// then pads on that unit, runs one pass per 16-bit slice on the 16x36
// multiplier and adder, and loads the output register; errors skip to the load.
// Sync reset clears the control state and acc; prod, sum and key_data are not reset.
// A stalled key beat holds; the next callsign may be taken meanwhile.
module callsign_hash22 (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  ch22_pkg::hash_in_t char_data,
  output logic               key_valid,
  input  logic               key_stall,
  output ch22_pkg::hash_out_t key_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCUM,
    S_PAD,
    S_MUL,
    S_ADD,
    S_FIN
  } state_t;

  state_t      state;
  logic [57:0] acc;
  logic [3:0]  sym_count;
  logic [3:0]  pend;
  logic        pend_bad;
  logic        seen_ns;
  logic        err_seen;
  logic [5:0]  cur_idx;
  logic        cur_last;
  logic [3:0]  spc_cnt;
  logic [1:0]  chunk_sel;
  logic [51:0] prod;
  logic [63:0] sum;

  logic          accept;
  ch22_pkg::sym_t sym;
  logic          white;
  logic [4:0]    total;
  logic          new_err;
  logic          final_err;
  logic          key_load;
  logic [5:0]    unit_add;
  logic [57:0]   unit_out;
  logic [63:0]   v_ext;
  logic [15:0]   chunk;
  logic [51:0]   mult_out;
  logic [63:0]   prod_shift;

  assign char_stall = (state != S_IDLE);
  assign accept     = char_valid && !char_stall;

  // Character decode and length check
  assign sym     = ch22_pkg::sym_lookup(char_data.char_code);
  assign white   = ch22_pkg::is_white(char_data.char_code);
  assign total   = {1'b0, sym_count} + {1'b0, pend} + 5'd1;
  assign new_err = err_seen || !sym.valid || pend_bad || (total > ch22_pkg::MAX_SYMBOLS);
  assign final_err = err_seen || !seen_ns || (sym_count == 4'd0);

  // Result load when the output register is free or being emptied
  assign key_load = (state == S_FIN) && (!key_valid || !key_stall);

  // Shared unit: acc * 38 + addend
  assign unit_add = (state == S_ACCUM && spc_cnt == 4'd0) ? cur_idx : 6'd0;
  assign unit_out = (acc << 5) + (acc << 2) + (acc << 1) + {52'd0, unit_add};

  // Hash multiply, one 16-bit slice per pass
  assign v_ext      = {6'd0, acc};
  assign chunk      = v_ext[{chunk_sel, 4'd0} +: 16];
  assign mult_out   = {36'd0, chunk} * {16'd0, ch22_pkg::HASH_MULT};
  assign prod_shift = {12'd0, prod} << {chunk_sel, 4'd0};

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      sym_count <= '0;
      pend      <= '0;
      pend_bad  <= 1'b0;
      seen_ns   <= 1'b0;
      err_seen  <= 1'b0;
      cur_last  <= 1'b0;
      spc_cnt   <= '0;
      chunk_sel <= '0;
      key_valid <= 1'b0;
    end else begin
      if (key_load) begin
        key_valid <= 1'b1;
      end else if (key_valid && !key_stall) begin
        key_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (white) begin
              if (seen_ns) begin
                if (pend != 4'hF) pend <= pend + 4'd1;
                if (char_data.char_code != ch22_pkg::CODE_SPACE) pend_bad <= 1'b1;
              end
              // Trailing blank ends the callsign: hash it unless in error
              if (char_data.last_char) state <= final_err ? S_FIN : S_PAD;
            end else begin
              seen_ns  <= 1'b1;
              err_seen <= new_err;
              pend     <= '0;
              pend_bad <= 1'b0;
              cur_last <= char_data.last_char;
              if (!new_err) begin
                cur_idx   <= sym.idx;
                spc_cnt   <= pend;
                sym_count <= total[3:0];
                state     <= S_ACCUM;
              end else if (char_data.last_char) begin
                state <= S_FIN;
              end
            end
          end
        end

        // Interior spaces, then the symbol itself
        S_ACCUM: begin
          acc <= unit_out;
          if (spc_cnt != 4'd0) begin
            spc_cnt <= spc_cnt - 4'd1;
          end else begin
            state <= cur_last ? S_PAD : S_IDLE;
          end
        end

        // Pad with symbol 0 up to full length
        S_PAD: begin
          if (sym_count < ch22_pkg::PAD_POSITIONS) begin
            acc       <= unit_out;
            sym_count <= sym_count + 4'd1;
          end else begin
            chunk_sel <= '0;
            sum       <= '0;
            state     <= S_MUL;
          end
        end

        S_MUL: begin
          prod  <= mult_out;
          state <= S_ADD;
        end

        S_ADD: begin
          sum <= sum + prod_shift;
          if (chunk_sel == 2'd3) begin
            state <= S_FIN;
          end else begin
            chunk_sel <= chunk_sel + 2'd1;
            state     <= S_MUL;
          end
        end

        // Load result once the output register is free
        S_FIN: begin
          if (key_load) begin
            key_data.hash_error <= final_err;
            key_data.key22      <= final_err ? 22'd0 : sum[63:42];
            key_data.key12      <= final_err ? 12'd0 : sum[63:52];
            acc       <= '0;
            sym_count <= '0;
            pend      <= '0;
            pend_bad  <= 1'b0;
            seen_ns   <= 1'b0;
            err_seen  <= 1'b0;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/ch22_checker.sv -----
// ----------------------------------------------------------------------------
// ch22_checker
// Port-level checks for callsign_hash22, bound into each of its instances.
// ----------------------------------------------------------------------------
`include "callsign_hash22_macros.svh"

module ch22_checker (
  input logic                clk,
  input logic                rst,
  input logic                char_valid,
  input logic                char_stall,
  input ch22_pkg::hash_in_t  char_data,
  input logic                key_valid,
  input logic                key_stall,
  input ch22_pkg::hash_out_t key_data
);

  // Stalled key beat holds
  `CH22_ASSERT(a_key_hold, key_valid && key_stall |=> key_valid && $stable(key_data), "key beat dropped or changed while stalled")

  // Error results carry a zero key
  `CH22_NEVER(a_err_zero, key_valid && key_data.hash_error && (key_data.key22 != 22'd0), "error result with nonzero key")

  // Short key is the top of the long key
  `CH22_NEVER(a_key12, key_valid && (key_data.key12 != key_data.key22[21:10]), "key12 does not match key22")

  // A last character keeps the block busy the next cycle
  `CH22_ASSERT(a_last_busy, char_valid && !char_stall && char_data.last_char |=> char_stall, "input not stalled after last character")

  // A new key beat follows a busy cycle
  `CH22_ASSERT(a_rise_busy, $rose(key_valid) |-> $past(char_stall), "key appeared without a finishing cycle")

endmodule

bind callsign_hash22 ch22_checker u_ch22_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds callsigns to callsign_hash22 one character a beat and checks every
// key beat against an in-bench hash predictor or a directed row's own key.
// A short directed list leads, then random callsigns, mostly well-formed,
// under several idle and stall mixes, with one long hold-off on the key side.
// ----------------------------------------------------------------------------
module testbench;

  localparam ch22_pkg::hash_out_t ERR_KEY =
    '{key22: 22'd0, key12: 12'd0, hash_error: 1'b1};
  localparam logic [63:0] MULT64 = 64'd47055833459;
  localparam int LONGEST = 11;
  localparam int ITEM_GOAL = 550;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    string               text;
    bit                  raw;
    logic [7:0]          raw_code;
    bit                  typed;
    ch22_pkg::hash_out_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                char_valid = 1'b0;
  logic                char_stall;
  ch22_pkg::hash_in_t  char_data = '0;
  logic                key_valid;
  logic                key_stall = 1'b0;
  ch22_pkg::hash_out_t key_data;

  // Predictor state
  logic [57:0] acc_v;
  logic [3:0]  nsym_v;
  logic [3:0]  npend_v;
  logic        seen_v;
  logic        err_v;
  logic        pend_bad_v;

  ch22_pkg::hash_out_t keys_due[$];
  logic [7:0]          word_q[$];
  ch22_pkg::hash_out_t key_head;
  dir_row_t   dir_rows[8];
  int         items_sent = 0;
  int         misses = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_go = 1'b0;
  bit         hold_done = 1'b0;
  int         hold_left = 0;

  callsign_hash22 dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .key_valid  (key_valid),
    .key_stall  (key_stall),
    .key_data   (key_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit is_ws(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Position in the 38-symbol alphabet, -1 when not in it
  function automatic int sym_pos(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c >= "a" && c <= "z") c = c - 8'h20;
    if (c == " ") return 0;
    if (c >= "0" && c <= "9") return int'(c - "0") + 1;
    if (c >= "A" && c <= "Z") return int'(c - "A") + 11;
    if (c == "/") return 37;
    return -1;
  endfunction

  task automatic clear_hash_state();
    acc_v = '0;
    nsym_v = '0;
    npend_v = '0;
    seen_v = 1'b0;
    err_v = 1'b0;
    pend_bad_v = 1'b0;
  endtask

  // Advance the callsign hash by one character; a key comes out on the last
  task automatic hash_char(input logic [7:0] c, input logic last, output bit got,
                           output ch22_pkg::hash_out_t key);
    int          idx;
    logic [4:0]  total;
    logic [63:0] v;
    bit          bad;
    got = 1'b0;
    key = '0;
    if (is_ws(c)) begin
      if (seen_v) begin
        if (npend_v != 4'd15) npend_v++;
        if (c != 8'h20) pend_bad_v = 1'b1;
      end
    end else begin
      idx = sym_pos(c);
      total = 5'(nsym_v) + 5'(npend_v) + 5'd1;
      seen_v = 1'b1;
      if (idx < 0 || pend_bad_v) err_v = 1'b1;
      if (total > 5'(LONGEST)) err_v = 1'b1;
      if (!err_v) begin
        repeat (npend_v) acc_v = acc_v * 58'd38;
        acc_v = acc_v * 58'd38 + 58'(idx);
        nsym_v = total[3:0];
      end
      npend_v = '0;
      pend_bad_v = 1'b0;
    end
    if (last) begin
      bad = err_v || !seen_v || nsym_v == 0;
      if (bad) begin
        key = ERR_KEY;
      end else begin
        v = 64'(acc_v);
        for (int i = nsym_v; i < LONGEST; i++) v = v * 64'd38;
        v = v * MULT64;
        key.key22 = v[63:42];
        key.key12 = v[63:52];
        key.hash_error = 1'b0;
      end
      got = 1'b1;
      clear_hash_state();
    end
  endtask

  // Offer every character of word_q, last one flagged, with random gaps
  task automatic send_word(input bit typed, input ch22_pkg::hash_out_t want);
    ch22_pkg::hash_out_t key;
    bit                  got;
    foreach (word_q[i]) begin
      while ($urandom_range(99) < send_idle_pct) begin
        @(negedge clk);
        char_valid <= 1'b0;
      end
      @(negedge clk);
      char_valid <= 1'b1;
      char_data <= '{char_code: word_q[i], last_char: (i == word_q.size() - 1)};
      do @(posedge clk); while (char_stall);
      hash_char(word_q[i], i == word_q.size() - 1, got, key);
      items_sent++;
      if (got) keys_due.push_back(typed ? want : key);
    end
  endtask

  function automatic logic [7:0] rand_ws();
    return ($urandom_range(1) == 1) ? 8'h20 : 8'h09 + 8'($urandom_range(4));
  endfunction

  // Non-space symbol, letters sometimes in lower case
  function automatic logic [7:0] rand_sym();
    int k;
    k = $urandom_range(1, 37);
    if (k <= 10) return 8'("0" + k - 1);
    if (k <= 36) return 8'(($urandom_range(1) == 1 ? "a" : "A") + k - 11);
    return "/";
  endfunction

  // Mostly well-formed callsigns with padding whitespace; the rest is noise
  task automatic make_word();
    int n;
    word_q.delete();
    if ($urandom_range(99) < 85) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(12, 13) : $urandom_range(1, LONGEST);
      repeat ($urandom_range(0, 2)) word_q.push_back(rand_ws());
      for (int i = 0; i < n; i++) begin
        if (i > 0 && i < n - 1 && $urandom_range(9) == 0)
          word_q.push_back(($urandom_range(4) == 0) ? rand_ws() : 8'h20);
        else
          word_q.push_back(rand_sym());
      end
      repeat ($urandom_range(0, 2)) word_q.push_back(rand_ws());
    end else if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) word_q.push_back(rand_ws());
    end else begin
      repeat ($urandom_range(1, 6)) word_q.push_back(8'($urandom_range(255)));
    end
  endtask

  // Key side: random stall, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      key_stall <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      key_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      key_stall <= 1'b1;
    end else begin
      key_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic note_miss(input string what, input ch22_pkg::hash_out_t want,
                           input ch22_pkg::hash_out_t got);
    misses++;
    if (misses <= 10)
      $display("%t key mismatch (%s): want %h/%h/%b, got %h/%h/%b",
               $realtime, what, want.key22, want.key12, want.hash_error,
               got.key22, got.key12, got.hash_error);
  endtask

  // Key beat check
  always @(posedge clk) begin
    if (!rst && key_valid && !key_stall) begin
      if (keys_due.size() == 0) begin
        note_miss("no key due", '0, key_data);
      end else begin
        key_head = keys_due.pop_front();
        if (key_data.key22 !== key_head.key22 || key_data.key12 !== key_head.key12 ||
            key_data.hash_error !== key_head.hash_error)
          note_miss("field", key_head, key_data);
      end
    end
  end

  initial begin
    // Directed callsigns: trimming, folding, symbol extremes, error cases
    dir_rows[0] = '{" k1abc\t", 1'b0, 8'h00, 1'b0, '0};
    dir_rows[1] = '{"Q",        1'b0, 8'h00, 1'b0, '0};
    dir_rows[2] = '{" ",        1'b0, 8'h00, 1'b1, ERR_KEY};
    dir_rows[3] = '{"",         1'b1, 8'h00, 1'b1, ERR_KEY};
    dir_rows[4] = '{"",         1'b1, 8'hFF, 1'b1, ERR_KEY};
    dir_rows[5] = '{"0/z",      1'b0, 8'h00, 1'b0, '0};
    dir_rows[6] = '{"A B",      1'b0, 8'h00, 1'b0, '0};
    dir_rows[7] = '{"A\nB",     1'b0, 8'h00, 1'b1, ERR_KEY};

    clear_hash_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      word_q.delete();
      if (dir_rows[r].raw) begin
        word_q.push_back(dir_rows[r].raw_code);
      end else begin
        for (int i = 0; i < dir_rows[r].text.len(); i++)
          word_q.push_back(dir_rows[r].text[i]);
      end
      send_word(dir_rows[r].typed, dir_rows[r].want);
    end

    // Long key-side hold-off while short callsigns keep coming
    hold_go = 1'b1;
    repeat (20) begin
      word_q.delete();
      word_q.push_back(rand_sym());
      word_q.push_back(rand_sym());
      send_word(1'b0, '0);
    end

    // Random callsigns in four idle/stall mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      while (items_sent < 60 + (p + 1) * (ITEM_GOAL - 60) / 4) begin
        make_word();
        send_word(1'b0, '0);
      end
    end

    @(negedge clk);
    char_valid <= 1'b0;
    wait (keys_due.size() == 0);
    repeat (60) @(posedge clk);
    if (misses == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Run limit
  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule
